// File: design/frr_pkg.sv
// Types and constants shared by the Fresnel reflectance pipeline.
// No dependencies.
package frr_pkg;

	localparam int unsigned CHANNELS = 4;
	localparam logic [15:0] REFL_ONE = 16'd32768;

	typedef struct packed {
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
		logic signed [15:0] norm_x;
		logic signed [15:0] norm_y;
		logic signed [15:0] norm_z;
		logic [15:0] ratio_red;
		logic [15:0] ratio_green;
		logic [15:0] ratio_blue;
		logic [15:0] ratio_fourth;
	} in_item_t;

	typedef struct packed {
		logic [15:0] refl_red;
		logic [15:0] refl_green;
		logic [15:0] refl_blue;
		logic [15:0] refl_fourth;
	} out_item_t;

endpackage

// File: design/frr_cos.sv
// Cosine front end: dot product, clamp and the sine-squared term.
// Depends on frr_pkg.
module frr_cos (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  frr_pkg::in_item_t in_item,
	output logic out_valid,
	output logic signed [29:0] c1,
	output logic [28:0] om28,
	output logic [63:0] ratios
);

	logic signed [31:0] px_s1, py_s1, pz_s1;
	logic [63:0] rat_s1, rat_s2, rat_s3;
	logic v_s1, v_s2, v_s3;
	logic signed [29:0] c1_s2, c1_s3;
	logic [28:0] om_s3;
	logic signed [33:0] dot;
	logic signed [33:0] neg;
	logic signed [59:0] sq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		px_s1 <= in_item.dir_x * in_item.norm_x;
		py_s1 <= in_item.dir_y * in_item.norm_y;
		pz_s1 <= in_item.dir_z * in_item.norm_z;
		rat_s1 <= {in_item.ratio_red, in_item.ratio_green, in_item.ratio_blue,
			in_item.ratio_fourth};
	end

	always_comb begin
		dot = 34'(px_s1) + 34'(py_s1) + 34'(pz_s1);
		neg = -dot;
	end

	always_ff @(posedge clk) begin
		if (neg > 34'sd268435456)
			c1_s2 <= 30'sd268435456;
		else if (neg < -34'sd268435456)
			c1_s2 <= -30'sd268435456;
		else
			c1_s2 <= neg[29:0];
		rat_s2 <= rat_s1;
	end

	assign sq = 60'(c1_s2) * 60'(c1_s2);

	always_ff @(posedge clk) begin
		om_s3 <= 29'(((60'sd1 <<< 56) - sq) >>> 28);
		c1_s3 <= c1_s2;
		rat_s3 <= rat_s2;
	end

	assign out_valid = v_s3;
	assign c1 = c1_s3;
	assign om28 = om_s3;
	assign ratios = rat_s3;

endmodule

// File: design/frr_chan.sv
// One colour channel: square root, two divisions and the final sum, pipelined.
// Depends on frr_pkg; no submodules.
module frr_chan (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic signed [29:0] c1,
	input  logic [28:0] om28,
	input  logic [15:0] ratio,
	output logic out_valid,
	output logic [15:0] refl
);

	localparam int SQ = 29;
	localparam int DV = 17;

	// stage p: ratio squared
	logic [31:0] rsq_p;
	logic [28:0] om_p;
	logic signed [29:0] c1_p;
	logic [15:0] r_p;
	logic v_p;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_p <= 1'b0;
		else v_p <= in_valid;
	end

	always_ff @(posedge clk) begin
		rsq_p <= 32'(ratio) * 32'(ratio);
		om_p <= om28;
		c1_p <= c1;
		r_p <= ratio;
	end

	// stage a: radicand
	logic [61:0] prod;
	logic tir_a, v_a;
	logic [56:0] rad_a;
	logic signed [29:0] c1_a;
	logic [15:0] r_a;

	assign prod = 62'(rsq_p) * 62'(om_p);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_a <= 1'b0;
		else v_a <= v_p;
	end

	always_ff @(posedge clk) begin
		tir_a <= prod > (62'd1 << 56);
		rad_a <= 57'((62'd1 << 56) - prod);
		c1_a <= c1_p;
		r_a <= r_p;
	end

	// square root, one result bit per stage
	logic [57:0] rem_q [SQ+1];
	logic [28:0] root_q [SQ+1];
	logic [57:0] rv_q [SQ+1];
	logic vs_q [SQ+1];
	logic ts_q [SQ+1];
	logic signed [29:0] cs_q [SQ+1];
	logic [15:0] rs_q [SQ+1];

	always_comb begin
		rem_q[0] = '0;
		root_q[0] = '0;
		rv_q[0] = {1'b0, rad_a};
		vs_q[0] = v_a;
		ts_q[0] = tir_a;
		cs_q[0] = c1_a;
		rs_q[0] = r_a;
	end

	for (genvar i = 0; i < SQ; i++) begin : g_sqrt
		logic [57:0] rem_n;
		logic [57:0] trial;
		assign rem_n = {rem_q[i][55:0], rv_q[i][57:56]};
		assign trial = {27'd0, root_q[i], 2'b01};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vs_q[i+1] <= 1'b0;
			else vs_q[i+1] <= vs_q[i];
		end
		always_ff @(posedge clk) begin
			if (rem_n >= trial) begin
				rem_q[i+1] <= rem_n - trial;
				root_q[i+1] <= {root_q[i][27:0], 1'b1};
			end else begin
				rem_q[i+1] <= rem_n;
				root_q[i+1] <= {root_q[i][27:0], 1'b0};
			end
			rv_q[i+1] <= {rv_q[i][55:0], 2'b00};
			ts_q[i+1] <= ts_q[i];
			cs_q[i+1] <= cs_q[i];
			rs_q[i+1] <= rs_q[i];
		end
	end

	// numerators and denominators (split products)
	logic signed [47:0] rc1, rc2, c2s, c1s;
	logic signed [48:0] ns_b, ds_b, np_b, dp_b;
	logic v_b, t_b;
	assign rc1 = 48'($signed({1'b0, rs_q[SQ]})) * 48'(cs_q[SQ]);
	assign rc2 = 48'($signed({1'b0, rs_q[SQ]})) * 48'($signed({1'b0, root_q[SQ]}));
	assign c2s = 48'($signed({1'b0, root_q[SQ]})) <<< 14;
	assign c1s = 48'(cs_q[SQ]) <<< 14;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_b <= 1'b0;
		else v_b <= vs_q[SQ];
	end

	always_ff @(posedge clk) begin
		ns_b <= 49'(rc1) - 49'(c2s);
		ds_b <= 49'(rc1) + 49'(c2s);
		np_b <= 49'(rc2) - 49'(c1s);
		dp_b <= 49'(rc2) + 49'(c1s);
		t_b <= ts_q[SQ];
	end

	// magnitudes and saturation flags
	logic [47:0] as_c, bs_c, ap_c, bp_c;
	logic v_c, one_c, sats_c, satp_c;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_c <= 1'b0;
		else v_c <= v_b;
	end
	always_ff @(posedge clk) begin
		logic [48:0] a0, b0, a1, b1;
		a0 = ns_b[48] ? -ns_b : ns_b;
		b0 = ds_b[48] ? -ds_b : ds_b;
		a1 = np_b[48] ? -np_b : np_b;
		b1 = dp_b[48] ? -dp_b : dp_b;
		as_c <= a0[47:0];
		bs_c <= b0[47:0];
		ap_c <= a1[47:0];
		bp_c <= b1[47:0];
		sats_c <= a0 >= b0;
		satp_c <= a1 >= b1;
		one_c <= t_b || (ds_b == '0) || (dp_b == '0);
	end

	// restoring division, one quotient bit per stage
	logic [48:0] rms_q [DV+1], rmp_q [DV+1];
	logic [47:0] dvs_q [DV+1], dvp_q [DV+1];
	logic [16:0] qs_q [DV+1], qp_q [DV+1];
	logic vd_q [DV+1], od_q [DV+1], ss_q [DV+1], sp_q [DV+1];

	always_comb begin
		rms_q[0] = {1'b0, as_c};
		rmp_q[0] = {1'b0, ap_c};
		dvs_q[0] = bs_c;
		dvp_q[0] = bp_c;
		qs_q[0] = '0;
		qp_q[0] = '0;
		vd_q[0] = v_c;
		od_q[0] = one_c;
		ss_q[0] = sats_c;
		sp_q[0] = satp_c;
	end

	for (genvar j = 0; j < DV; j++) begin : g_div
		logic [49:0] ts, tp;
		assign ts = (j == 0) ? {1'b0, rms_q[j]} : {rms_q[j], 1'b0};
		assign tp = (j == 0) ? {1'b0, rmp_q[j]} : {rmp_q[j], 1'b0};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vd_q[j+1] <= 1'b0;
			else vd_q[j+1] <= vd_q[j];
		end
		always_ff @(posedge clk) begin
			if (ts >= {2'b00, dvs_q[j]}) begin
				rms_q[j+1] <= 49'(ts - {2'b00, dvs_q[j]});
				qs_q[j+1] <= {qs_q[j][15:0], 1'b1};
			end else begin
				rms_q[j+1] <= ts[48:0];
				qs_q[j+1] <= {qs_q[j][15:0], 1'b0};
			end
			if (tp >= {2'b00, dvp_q[j]}) begin
				rmp_q[j+1] <= 49'(tp - {2'b00, dvp_q[j]});
				qp_q[j+1] <= {qp_q[j][15:0], 1'b1};
			end else begin
				rmp_q[j+1] <= tp[48:0];
				qp_q[j+1] <= {qp_q[j][15:0], 1'b0};
			end
			dvs_q[j+1] <= dvs_q[j];
			dvp_q[j+1] <= dvp_q[j];
			od_q[j+1] <= od_q[j];
			ss_q[j+1] <= ss_q[j];
			sp_q[j+1] <= sp_q[j];
		end
	end

	// squares
	logic [16:0] fs, fp;
	logic [33:0] sqs_e, sqp_e;
	logic v_e, o_e;
	assign fs = ss_q[DV] ? 17'h10000 : qs_q[DV];
	assign fp = sp_q[DV] ? 17'h10000 : qp_q[DV];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_e <= 1'b0;
		else v_e <= vd_q[DV];
	end
	always_ff @(posedge clk) begin
		sqs_e <= 34'(fs) * 34'(fs);
		sqp_e <= 34'(fp) * 34'(fp);
		o_e <= od_q[DV];
	end

	// sum, round and saturate
	logic [34:0] sum;
	logic [16:0] rnd;
	logic v_f;
	assign sum = 35'(sqs_e) + 35'(sqp_e) + 35'(1 << 17);
	assign rnd = sum[34:18];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_f <= 1'b0;
		else v_f <= v_e;
	end

	always_ff @(posedge clk) begin
		if (o_e || rnd > 17'(frr_pkg::REFL_ONE))
			refl <= frr_pkg::REFL_ONE;
		else
			refl <= rnd[15:0];
	end

	assign out_valid = v_f;

endmodule

// File: design/fresnel_reflectance_rgbw_top.sv
// Unpolarised Fresnel reflectance, four channels, fully pipelined.
// The pipeline depth is set mostly by the bit-per-stage square root (29 stages) and
// dividers (17 stages); one item per cycle.
// busy is always low: the receiver cannot stall, so no transfer waits.
// Reset clears all valid bits; payload registers are not reset.
// Depends on frr_pkg, frr_cos and frr_chan.
module fresnel_reflectance_rgbw_top (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  frr_pkg::in_item_t in_item,
	output logic strobe,
	output frr_pkg::out_item_t result
);

	logic cv;
	logic signed [29:0] c1;
	logic [28:0] om28;
	logic [63:0] ratios;
	logic [15:0] refl [frr_pkg::CHANNELS];
	logic [frr_pkg::CHANNELS-1:0] chv;

	assign busy = 1'b0;

	frr_cos u_cos (
		.clk(clk), .arst_n(arst_n), .in_valid(start), .in_item(in_item),
		.out_valid(cv), .c1(c1), .om28(om28), .ratios(ratios)
	);

	for (genvar k = 0; k < frr_pkg::CHANNELS; k++) begin : g_ch
		frr_chan u_chan (
			.clk(clk), .arst_n(arst_n), .in_valid(cv), .c1(c1), .om28(om28),
			.ratio(ratios[63-16*k -: 16]), .out_valid(chv[k]), .refl(refl[k])
		);
	end

	assign strobe = &chv;
	assign result = {refl[0], refl[1], refl[2], refl[3]};

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the four-channel Fresnel reflectance pipeline.
// Drives random and directed rays, predicts each reflectance in fixed point
// and compares every strobed result. Depends on frr_pkg and the top level.
module tb_top;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	frr_pkg::in_item_t in_item = '0;
	logic strobe;
	frr_pkg::out_item_t result;

	frr_pkg::in_item_t pending_rays[$];
	frr_pkg::out_item_t expected_refl[$];
	int errors = 0;
	int cycles = 0;
	int send_idle_pct = 16;
	bit hold_sender = 1'b0;
	bit stim_done = 1'b0;

	localparam int LATENCY = 54;
	localparam int CYCLE_LIMIT = 200000;

	fresnel_reflectance_rgbw_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.in_item(in_item), .strobe(strobe), .result(result)
	);

	always #5 clk = ~clk;

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] root;
		logic [63:0] bitv;
		root = 64'd0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v = v - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	function automatic longint unsigned ratio_q16(longint num, longint den);
		longint unsigned a;
		longint unsigned b;
		a = num < 0 ? -num : num;
		b = den < 0 ? -den : den;
		if (a >= b) return 64'd65536;
		return (a << 16) / b;
	endfunction

	function automatic logic [15:0] channel_refl(longint c1, longint unsigned om28,
			logic [15:0] ratio);
		longint r;
		longint unsigned prod;
		longint c2;
		longint ns, ds, np, dp;
		longint unsigned qs, qp, total;
		r = longint'(ratio);
		prod = longint'(r * r) * om28;
		if (prod > (64'd1 << 56)) return frr_pkg::REFL_ONE;
		c2 = int_sqrt((64'd1 << 56) - prod);
		ns = r * c1 - c2 * 16384;
		ds = r * c1 + c2 * 16384;
		np = r * c2 - c1 * 16384;
		dp = r * c2 + c1 * 16384;
		if (ds == 0 || dp == 0) return frr_pkg::REFL_ONE;
		qs = ratio_q16(ns, ds);
		qp = ratio_q16(np, dp);
		total = (qs * qs + qp * qp + (64'd1 << 17)) >> 18;
		if (total > frr_pkg::REFL_ONE) total = frr_pkg::REFL_ONE;
		return total[15:0];
	endfunction

	function automatic frr_pkg::out_item_t fresnel_predict(frr_pkg::in_item_t ray);
		longint c1;
		longint unsigned om28;
		frr_pkg::out_item_t refl;
		c1 = -(longint'(ray.dir_x) * ray.norm_x + longint'(ray.dir_y) * ray.norm_y
			+ longint'(ray.dir_z) * ray.norm_z);
		if (c1 > (64'sd1 << 28)) c1 = 64'sd1 << 28;
		if (c1 < -(64'sd1 << 28)) c1 = -(64'sd1 << 28);
		om28 = longint'((64'sd1 << 56) - c1 * c1) >>> 28;
		refl.refl_red = channel_refl(c1, om28, ray.ratio_red);
		refl.refl_green = channel_refl(c1, om28, ray.ratio_green);
		refl.refl_blue = channel_refl(c1, om28, ray.ratio_blue);
		refl.refl_fourth = channel_refl(c1, om28, ray.ratio_fourth);
		return refl;
	endfunction

	function automatic logic signed [15:0] rand_comp();
		return $signed(16'($urandom_range(32768)) - 16'd16384);
	endfunction

	function automatic frr_pkg::in_item_t rand_ray();
		frr_pkg::in_item_t ray;
		real dx, dy, dz, nx, ny, nz, len;
		int mode;
		mode = $urandom_range(9);
		dx = $itor(rand_comp()); dy = $itor(rand_comp()); dz = $itor(rand_comp());
		nx = $itor(rand_comp()); ny = $itor(rand_comp()); nz = $itor(rand_comp());
		if (mode < 7) begin
			// Normalise both vectors so that most rays are physically sensible.
			len = $sqrt(dx * dx + dy * dy + dz * dz) + 1.0;
			dx = dx / len * 16384.0; dy = dy / len * 16384.0; dz = dz / len * 16384.0;
			len = $sqrt(nx * nx + ny * ny + nz * nz) + 1.0;
			nx = nx / len * 16384.0; ny = ny / len * 16384.0; nz = nz / len * 16384.0;
		end
		ray.dir_x = 16'($rtoi(dx)); ray.dir_y = 16'($rtoi(dy));
		ray.dir_z = 16'($rtoi(dz));
		ray.norm_x = 16'($rtoi(nx)); ray.norm_y = 16'($rtoi(ny));
		ray.norm_z = 16'($rtoi(nz));
		if (mode == 9) begin
			ray.ratio_red = 16'($urandom); ray.ratio_green = 16'($urandom);
			ray.ratio_blue = 16'($urandom); ray.ratio_fourth = 16'($urandom);
		end else begin
			ray.ratio_red = 16'($urandom_range(8192, 32768));
			ray.ratio_green = 16'($urandom_range(8192, 32768));
			ray.ratio_blue = 16'($urandom_range(1, 65535));
			ray.ratio_fourth = 16'($urandom_range(12000, 26000));
		end
		return ray;
	endfunction

	function automatic frr_pkg::in_item_t make_ray(int dx, int dy, int dz, int nx, int ny,
			int nz, int r0, int r1, int r2, int r3);
		frr_pkg::in_item_t ray;
		ray.dir_x = 16'(dx); ray.dir_y = 16'(dy); ray.dir_z = 16'(dz);
		ray.norm_x = 16'(nx); ray.norm_y = 16'(ny); ray.norm_z = 16'(nz);
		ray.ratio_red = 16'(r0); ray.ratio_green = 16'(r1);
		ray.ratio_blue = 16'(r2); ray.ratio_fourth = 16'(r3);
		return ray;
	endfunction

	always @(negedge clk) begin
		if (arst_n && !hold_sender && pending_rays.size() > 0 &&
				$urandom_range(99) >= send_idle_pct) begin
			start <= 1'b1;
			in_item <= pending_rays.pop_front();
		end else begin
			start <= 1'b0;
			in_item <= rand_ray();
		end
	end

	always @(posedge clk) begin
		frr_pkg::out_item_t want;
		cycles <= cycles + 1;
		if (start && !busy) expected_refl.push_back(fresnel_predict(in_item));
		if (strobe) begin
			if (expected_refl.size() == 0) begin
				errors++;
				$display("%0t: result %h with none expected", $time, result);
			end else begin
				want = expected_refl.pop_front();
				if (want.refl_red !== result.refl_red ||
						want.refl_green !== result.refl_green ||
						want.refl_blue !== result.refl_blue ||
						want.refl_fourth !== result.refl_fourth) begin
					errors++;
					$display("%0t: expected %h actual %h", $time, want, result);
				end
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		// Head-on, grazing, leaving, total internal reflection, zero and extreme ratios.
		pending_rays.push_back(make_ray(0, 0, -16384, 0, 0, 16384, 16384, 10923, 21845, 0));
		pending_rays.push_back(make_ray(16384, 0, 0, 0, 0, 16384, 16384, 10923, 24576, 1));
		pending_rays.push_back(make_ray(0, 0, 16384, 0, 0, 16384, 10923, 16384, 65535, 8192));
		pending_rays.push_back(make_ray(11585, 0, -11585, 0, 0, 16384, 24576, 32768, 16384, 1));
		pending_rays.push_back(make_ray(-16384, -16384, -16384, 16384, 16384, 16384,
			65535, 0, 16384, 20000));
		pending_rays.push_back(make_ray(16384, 16384, 16384, 16384, 16384, 16384,
			32767, 32768, 1, 65535));
		pending_rays.push_back(make_ray(-32768, -32768, -32768, -32768, -32768, -32768,
			16384, 8192, 0, 65535));
		pending_rays.push_back(make_ray(32767, 32767, 32767, -32768, -32768, -32768,
			16384, 0, 32768, 100));
		pending_rays.push_back(make_ray(0, 0, 0, 0, 0, 0, 0, 16384, 21845, 65535));
		pending_rays.push_back(make_ray(-1, -1, -1, -1, -1, -1, 16'hAAAA, 16'h5555, 1, 2));
		pending_rays.push_back(make_ray(16384, 0, -1, 0, 0, 16384, 16384, 16385, 16383, 20000));
		pending_rays.push_back(make_ray(0, 16384, 0, 0, 16384, 0, 13107, 19661, 0, 65535));
		for (int i = 0; i < 460; i++) pending_rays.push_back(rand_ray());
		wait (pending_rays.size() == 0 && expected_refl.size() == 0);
		hold_sender = 1'b1;
		send_idle_pct = 85;
		@(negedge clk) hold_sender = 1'b0;
		for (int i = 0; i < 470; i++) pending_rays.push_back(rand_ray());
		wait (pending_rays.size() == 0);
		send_idle_pct = 0;
		for (int i = 0; i < 470; i++) pending_rays.push_back(rand_ray());
		wait (pending_rays.size() == 0);
		@(posedge clk);
		wait (expected_refl.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
